// ----- hw/rtl/sqie_pkg.sv -----
`timescale 1ns / 1ps

package sqie_pkg;

  // Port widths of the item fields
  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 7;

  // Defaults for the top level parameters
  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd5;
  localparam logic [MODE_W-1:0] MODE_READ       = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd7;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Work the controller carries out for one item
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ERA  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POPB = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLR  = 3'd5;

  // Memory read address select
  localparam int RSEL_W = 3;
  localparam logic [RSEL_W-1:0] RSEL_PREV = 3'd0;
  localparam logic [RSEL_W-1:0] RSEL_NEXT = 3'd1;
  localparam logic [RSEL_W-1:0] RSEL_ZERO = 3'd2;
  localparam logic [RSEL_W-1:0] RSEL_LAST = 3'd3;
  localparam logic [RSEL_W-1:0] RSEL_POS  = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic              latch;
    logic              plan;
    logic              idx_dec;
    logic              idx_inc;
    logic [RSEL_W-1:0] rd_sel;
    logic              wr_shift;
    logic              wr_put;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              cnt_clr;
    logic              cap_front;
    logic              cap_back;
    logic              cap_read;
    logic              load_out;
  } sqie_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              up_done;
    logic              dn_done;
  } sqie_stat_t;

endpackage

// ----- hw/rtl/sqie_dp.sv -----
`timescale 1ns / 1ps

module sqie_dp #(
  parameter int DEPTH      = sqie_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = sqie_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sqie_pkg::sqie_cmd_t         cmd,
  output sqie_pkg::sqie_stat_t        stat,
  input  logic [sqie_pkg::MODE_W-1:0] mode,
  input  logic [sqie_pkg::POS_W-1:0]  position,
  input  logic [sqie_pkg::VAL_W-1:0]  value,
  output logic [sqie_pkg::STAT_W-1:0] status,
  output logic [sqie_pkg::VAL_W-1:0]  read_value,
  output logic [sqie_pkg::COUNT_W-1:0] count,
  output logic [sqie_pkg::VAL_W-1:0]  front_value,
  output logic [sqie_pkg::VAL_W-1:0]  back_value
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = sqie_pkg::POS_W;
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int VW     = sqie_pkg::VAL_W;
  localparam int OCW    = sqie_pkg::COUNT_W;

  logic [sqie_pkg::MODE_W-1:0]   mode_q;
  logic [POS_W-1:0]              pos_in_q;
  logic [DATA_WIDTH-1:0]         val_q;
  logic [CNT_W-1:0]              cnt;
  logic [sqie_pkg::KIND_W-1:0]   kind_q;
  logic [sqie_pkg::STAT_W-1:0]   status_q;
  logic [CMP_W-1:0]              pos_q;
  logic [ADDR_W-1:0]             idx;
  logic [DATA_WIDTH-1:0]         mem [DEPTH];
  logic [DATA_WIDTH-1:0]         rdata;
  logic [DATA_WIDTH-1:0]         front_q;
  logic [DATA_WIDTH-1:0]         back_q;
  logic [DATA_WIDTH-1:0]         rd_q;

  logic [sqie_pkg::KIND_W-1:0]   plan_kind;
  logic [sqie_pkg::STAT_W-1:0]   plan_status;
  logic [CMP_W-1:0]              plan_pos;
  logic [CMP_W-1:0]              pos_w;
  logic [CMP_W-1:0]              cnt_w;
  logic                          full;
  logic                          empty;
  logic [ADDR_W-1:0]             rd_addr;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic [DATA_WIDTH-1:0]         wr_data;

  assign pos_w = CMP_W'(pos_in_q);
  assign cnt_w = CMP_W'(cnt);
  assign full  = (cnt_w == CMP_W'(DEPTH));
  assign empty = (cnt == '0);

  // Request decode against the current count
  always_comb begin
    plan_kind   = sqie_pkg::KIND_NONE;
    plan_status = sqie_pkg::ST_OK;
    plan_pos    = pos_w;
    case (mode_q)
      sqie_pkg::MODE_PUSH_BACK: begin
        plan_pos = cnt_w;
        if (full) plan_status = sqie_pkg::ST_FULL;
        else plan_kind = sqie_pkg::KIND_INS;
      end
      sqie_pkg::MODE_PUSH_FRONT: begin
        plan_pos = '0;
        if (full) plan_status = sqie_pkg::ST_FULL;
        else plan_kind = sqie_pkg::KIND_INS;
      end
      sqie_pkg::MODE_POP_BACK: begin
        if (empty) plan_status = sqie_pkg::ST_EMPTY;
        else plan_kind = sqie_pkg::KIND_POPB;
      end
      sqie_pkg::MODE_POP_FRONT: begin
        plan_pos = '0;
        if (empty) plan_status = sqie_pkg::ST_EMPTY;
        else plan_kind = sqie_pkg::KIND_ERA;
      end
      sqie_pkg::MODE_INSERT: begin
        if (pos_w > cnt_w) plan_status = sqie_pkg::ST_RANGE;
        else if (full) plan_status = sqie_pkg::ST_FULL;
        else plan_kind = sqie_pkg::KIND_INS;
      end
      sqie_pkg::MODE_ERASE: begin
        if (pos_w >= cnt_w) plan_status = sqie_pkg::ST_RANGE;
        else plan_kind = sqie_pkg::KIND_ERA;
      end
      sqie_pkg::MODE_READ: begin
        if (pos_w >= cnt_w) plan_status = sqie_pkg::ST_RANGE;
        else plan_kind = sqie_pkg::KIND_READ;
      end
      sqie_pkg::MODE_CLEAR: begin
        plan_kind = sqie_pkg::KIND_CLR;
      end
      default: begin
        plan_kind = sqie_pkg::KIND_NONE;
      end
    endcase
  end

  // Plan kind and loop end flags for the shift sequences
  assign stat.kind    = plan_kind;
  assign stat.up_done = (CMP_W'(idx) == pos_q);
  assign stat.dn_done = !((CMP_W'(idx) + CMP_W'(1)) < cnt_w);

  // Read address select
  always_comb begin
    case (cmd.rd_sel)
      sqie_pkg::RSEL_PREV: rd_addr = idx - ADDR_W'(1);
      sqie_pkg::RSEL_NEXT: rd_addr = idx + ADDR_W'(1);
      sqie_pkg::RSEL_ZERO: rd_addr = '0;
      sqie_pkg::RSEL_LAST: rd_addr = ADDR_W'(cnt - CNT_W'(1));
      sqie_pkg::RSEL_POS:  rd_addr = ADDR_W'(pos_q);
      default:             rd_addr = '0;
    endcase
  end

  // Write port: shifted word or the new word
  assign wr_en   = cmd.wr_shift | cmd.wr_put;
  assign wr_addr = cmd.wr_put ? ADDR_W'(pos_q) : idx;
  assign wr_data = cmd.wr_put ? val_q : rdata;

  // Entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // Request and plan registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q   <= mode;
      pos_in_q <= position;
      val_q    <= DATA_WIDTH'(value);
    end
    if (cmd.plan) begin
      kind_q   <= plan_kind;
      status_q <= plan_status;
      pos_q    <= plan_pos;
    end
  end

  // Shift index
  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      if (plan_kind == sqie_pkg::KIND_INS) idx <= ADDR_W'(cnt);
      else idx <= ADDR_W'(plan_pos);
    end else if (cmd.idx_dec) begin
      idx <= idx - ADDR_W'(1);
    end else if (cmd.idx_inc) begin
      idx <= idx + ADDR_W'(1);
    end
  end

  // Element count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Front, back and read word captures
  always_ff @(posedge clk) begin
    if (cmd.cap_front) front_q <= rdata;
    if (cmd.cap_back) back_q <= rdata;
    if (cmd.cap_read) rd_q <= (kind_q == sqie_pkg::KIND_READ) ? rdata : '0;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= status_q;
      read_value  <= VW'(rd_q);
      count       <= OCW'(cnt);
      front_value <= empty ? '0 : VW'(front_q);
      back_value  <= empty ? '0 : VW'(back_q);
    end
  end

endmodule

// ----- hw/rtl/sqie_ctrl.sv -----
`timescale 1ns / 1ps

module sqie_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sqie_pkg::sqie_stat_t stat,
  output sqie_pkg::sqie_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PLAN  = 4'd1;
  localparam logic [3:0] S_UP_RD = 4'd2;
  localparam logic [3:0] S_UP_WR = 4'd3;
  localparam logic [3:0] S_PUT   = 4'd4;
  localparam logic [3:0] S_DN_RD = 4'd5;
  localparam logic [3:0] S_DN_WR = 4'd6;
  localparam logic [3:0] S_FRONT = 4'd7;
  localparam logic [3:0] S_BACK  = 4'd8;
  localparam logic [3:0] S_RDP   = 4'd9;
  localparam logic [3:0] S_RDD   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = sqie_pkg::RSEL_ZERO;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd.plan = 1'b1;
        case (stat.kind)
          sqie_pkg::KIND_INS: state_next = S_UP_RD;
          sqie_pkg::KIND_ERA: state_next = S_DN_RD;
          sqie_pkg::KIND_POPB: begin
            cmd.cnt_dec = 1'b1;
            state_next  = S_FRONT;
          end
          sqie_pkg::KIND_CLR: begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_FRONT;
          end
          default: state_next = S_FRONT;
        endcase
      end
      // open a gap: move entries up one place, top first
      S_UP_RD: begin
        if (stat.up_done) begin
          state_next = S_PUT;
        end else begin
          cmd.rd_sel = sqie_pkg::RSEL_PREV;
          state_next = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_next   = S_UP_RD;
      end
      S_PUT: begin
        cmd.wr_put  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = S_FRONT;
      end
      // close a gap: move entries down one place, bottom first
      S_DN_RD: begin
        if (stat.dn_done) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_FRONT;
        end else begin
          cmd.rd_sel = sqie_pkg::RSEL_NEXT;
          state_next = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_DN_RD;
      end
      // fetch front, back and read words
      S_FRONT: begin
        cmd.rd_sel = sqie_pkg::RSEL_ZERO;
        state_next = S_BACK;
      end
      S_BACK: begin
        cmd.cap_front = 1'b1;
        cmd.rd_sel    = sqie_pkg::RSEL_LAST;
        state_next    = S_RDP;
      end
      S_RDP: begin
        cmd.cap_back = 1'b1;
        cmd.rd_sel   = sqie_pkg::RSEL_POS;
        state_next   = S_RDD;
      end
      S_RDD: begin
        cmd.cap_read = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/sequence_store_insert_erase.sv -----
`timescale 1ns / 1ps

// Channel  Handshake            Fields
// in       in_valid / in_ready  mode, position, value
// out      out_valid/out_ready  status, read_value, count, front_value, back_value
//
// One item at a time. After acceptance the item is planned, then entries are
// shifted where needed for insert, erase and the pushes and pops, with one read
// and one write per moved entry, then the front, back and read words are fetched
// before the result is loaded. The result sits in an output register, so the next item is
// taken while it waits; that item then stalls until the register is free.
// Reset clears the count and the control state; the entry memory is not cleared.

module sequence_store_insert_erase #(
  parameter int DEPTH      = sqie_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = sqie_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sqie_pkg::MODE_W-1:0]  mode,
  input  logic [sqie_pkg::POS_W-1:0]   position,
  input  logic [sqie_pkg::VAL_W-1:0]   value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sqie_pkg::STAT_W-1:0]  status,
  output logic [sqie_pkg::VAL_W-1:0]   read_value,
  output logic [sqie_pkg::COUNT_W-1:0] count,
  output logic [sqie_pkg::VAL_W-1:0]   front_value,
  output logic [sqie_pkg::VAL_W-1:0]   back_value
);

  sqie_pkg::sqie_cmd_t  cmd;
  sqie_pkg::sqie_stat_t stat;

  sqie_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sqie_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .position    (position),
    .value       (value),
    .status      (status),
    .read_value  (read_value),
    .count       (count),
    .front_value (front_value),
    .back_value  (back_value)
  );

  // one item in flight: no acceptance right after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

  // an empty status leaves the store empty
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == sqie_pkg::ST_EMPTY) |-> (count == '0))
    else $error("empty status with nonzero count");

  // a read word only comes with an ok status
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_value != '0) |-> (status == sqie_pkg::ST_OK))
    else $error("read word on a refused item");

endmodule
